/* src/dts_pkg.sv */
// Shared constants, codes and entry types of the DFA token scanner.
`default_nettype none

package dts_pkg;

  // DFA geometry
  localparam int STATE_BITS      = 8;
  localparam int NUM_STATES      = 1 << STATE_BITS;
  localparam int SYM_BITS        = 7;
  localparam int NUM_SYMBOLS     = 1 << SYM_BITS;
  localparam int TRANS_ADDR_BITS = STATE_BITS + SYM_BITS;
  localparam int TRANS_DEPTH     = NUM_STATES * NUM_SYMBOLS;

  // Attribute priorities
  localparam int PRIO_BITS      = 6;
  localparam int NUM_PRIORITIES = 64;
  localparam logic [PRIO_BITS-1:0] PRIO_MAX = PRIO_BITS'(NUM_PRIORITIES - 1);

  // Token length counter and its output field
  localparam int LENGTH_BITS    = 16;
  localparam int TOKEN_LEN_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Operation codes
  localparam int OP_BITS = 2;
  localparam logic [OP_BITS-1:0] OP_WR_TRANS = 2'd0;
  localparam logic [OP_BITS-1:0] OP_WR_INFO  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_SCAN     = 2'd2;

  typedef struct packed {
    logic                  live;
    logic [STATE_BITS-1:0] next;
  } trans_entry_t;

  typedef struct packed {
    logic                 accepts;
    logic [PRIO_BITS-1:0] prio;
  } info_entry_t;

  // Transition memory access: one shared address for write or read
  typedef struct packed {
    logic                       wr_en;
    logic                       rd_en;
    logic [TRANS_ADDR_BITS-1:0] addr;
    trans_entry_t               wdata;
  } trans_req_t;

  // State info memory access: one write port, two read ports
  typedef struct packed {
    logic                  wr_en;
    logic [STATE_BITS-1:0] waddr;
    info_entry_t           wdata;
    logic                  rd_a_en;
    logic [STATE_BITS-1:0] rd_a_addr;
    logic                  rd_b_en;
    logic [STATE_BITS-1:0] rd_b_addr;
  } info_req_t;

endpackage

`default_nettype wire

/* src/dts_in_if.sv */
// Input channel of the scanner: load and scan items with valid/ready.
`default_nettype none

interface dts_in_if;
  import dts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    operation;
  logic [STATE_BITS-1:0] table_state;
  logic [SYM_BITS-1:0]   symbol;
  logic [STATE_BITS-1:0] target_state;
  logic                  target_live;
  logic                  state_accepts;
  logic [PRIO_BITS-1:0]  state_priority;
  logic                  begin_token;
  logic                  end_of_text;

  modport source (
    output valid, operation, table_state, symbol, target_state, target_live,
           state_accepts, state_priority, begin_token, end_of_text,
    input  ready
  );

  modport sink (
    input  valid, operation, table_state, symbol, target_state, target_live,
           state_accepts, state_priority, begin_token, end_of_text,
    output ready
  );
endinterface

`default_nettype wire

/* src/dts_out_if.sv */
// Result channel of the scanner: one token beat per stopped scan.
`default_nettype none

interface dts_out_if;
  import dts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [PRIO_BITS-1:0]      token_kind;
  logic [TOKEN_LEN_BITS-1:0] token_length;
  logic                      final_accepting;

  modport source (
    output valid, token_kind, token_length, final_accepting,
    input  ready
  );

  modport sink (
    input  valid, token_kind, token_length, final_accepting,
    output ready
  );
endinterface

`default_nettype wire

/* src/dts_trans_mem.sv */
// Transition table memory: one port, registered read data.
`default_nettype none

module dts_trans_mem (
  input  wire logic                  clk,
  input  wire dts_pkg::trans_req_t   req,
  output dts_pkg::trans_entry_t      rd_data
);
  import dts_pkg::*;

  trans_entry_t mem [TRANS_DEPTH];
  trans_entry_t rd_data_r;

  // Write or read the addressed entry; read data holds between reads
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/dts_info_mem.sv */
// State info memory: one write port and two registered read ports.
`default_nettype none

module dts_info_mem (
  input  wire logic                 clk,
  input  wire dts_pkg::info_req_t   req,
  output dts_pkg::info_entry_t      rd_a_data,
  output dts_pkg::info_entry_t      rd_b_data
);
  import dts_pkg::*;

  info_entry_t mem [NUM_STATES];
  info_entry_t rd_a_r;
  info_entry_t rd_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read ports: current state info and next state info
  always_ff @(posedge clk) begin
    if (req.rd_a_en) begin
      rd_a_r <= mem[req.rd_a_addr];
    end
    if (req.rd_b_en) begin
      rd_b_r <= mem[req.rd_b_addr];
    end
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

`default_nettype wire

/* src/dts_scan_ctrl.sv */
// Scan pipeline: issues table accesses, decides stops and holds the result beat.
`default_nettype none

module dts_scan_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  dts_in_if.sink                      in_bus,
  dts_out_if.source                   out_bus,
  output dts_pkg::trans_req_t         trans_req,
  input  wire dts_pkg::trans_entry_t  trans_rd,
  output dts_pkg::info_req_t          info_req,
  input  wire dts_pkg::info_entry_t   info_rd_a,
  input  wire dts_pkg::info_entry_t   info_rd_b
);
  import dts_pkg::*;

  // Front end
  logic                  in_fire;
  logic                  is_scan;
  logic [STATE_BITS-1:0] scan_state;
  logic [PRIO_BITS-1:0]  prio_sat;

  // Pipeline registers
  logic                  busy_r;
  logic                  b_valid_r;
  logic                  b_begin_r;
  logic                  b_eot_r;
  logic                  b_act;
  logic                  c_valid_r;
  logic                  c_valid_nxt;
  logic                  c_act_r;
  logic                  c_begin_r;
  logic                  c_eot_r;

  // Scan state
  logic                  active_r;
  logic [STATE_BITS-1:0] cur_r;
  logic [LENGTH_BITS-1:0] cnt_r;
  logic [LENGTH_BITS-1:0] cnt_base;

  // Decision
  logic                  c_emit;
  logic                  c_move;
  info_entry_t           c_kept;
  logic                  c_stall;
  logic                  c_fire;

  // Result beat
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [PRIO_BITS-1:0]      out_kind_r;
  logic [TOKEN_LEN_BITS-1:0] out_len_r;
  logic                      out_acc_r;

  assign in_fire    = in_bus.valid & in_bus.ready;
  assign is_scan    = (in_bus.operation == OP_SCAN);
  assign scan_state = in_bus.begin_token ? '0 : cur_r;
  assign prio_sat   = (in_bus.state_priority > PRIO_MAX) ? PRIO_MAX : in_bus.state_priority;

  // Issue table accesses for the accepted beat
  always_comb begin
    trans_req.wr_en      = in_fire & (in_bus.operation == OP_WR_TRANS);
    trans_req.rd_en      = in_fire & is_scan;
    trans_req.addr       = trans_req.wr_en ? {in_bus.table_state, in_bus.symbol}
                                           : {scan_state, in_bus.symbol};
    trans_req.wdata.live = in_bus.target_live;
    trans_req.wdata.next = in_bus.target_state;

    info_req.wr_en         = in_fire & (in_bus.operation == OP_WR_INFO);
    info_req.waddr         = in_bus.table_state;
    info_req.wdata.accepts = in_bus.state_accepts;
    info_req.wdata.prio    = prio_sat;
    info_req.rd_a_en       = in_fire & is_scan;
    info_req.rd_a_addr     = scan_state;
    info_req.rd_b_en       = b_valid_r;
    info_req.rd_b_addr     = trans_rd.next;
  end

  // Stop decision on transition entry, current and next state info
  assign cnt_base = c_begin_r ? '0 : cnt_r;

  always_comb begin
    c_emit = 1'b0;
    c_move = 1'b0;
    c_kept = info_rd_a;
    if (c_act_r) begin
      if (!trans_rd.live) begin
        c_emit = 1'b1;
      end else if (info_rd_a.accepts && (info_rd_b.prio > info_rd_a.prio)) begin
        c_emit = 1'b1;
        c_kept = info_rd_b;
      end else if (c_eot_r) begin
        c_emit = 1'b1;
      end else begin
        c_move = 1'b1;
      end
    end
  end

  assign c_stall = c_valid_r & c_emit & out_valid_r & ~out_bus.ready;
  assign c_fire  = c_valid_r & ~c_stall;
  assign b_act   = b_begin_r | active_r;

  // Not ready while busy with the last accepted beat; hold off in reset and while a result cannot drain
  assign in_bus.ready = rst_n & ~busy_r & ~c_stall;

  // Advance stage control
  always_comb begin
    c_valid_nxt = c_valid_r;
    if (b_valid_r) begin
      c_valid_nxt = 1'b1;
    end else if (c_fire) begin
      c_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      busy_r    <= in_fire;
      b_valid_r <= in_fire & is_scan;
      c_valid_r <= c_valid_nxt;
    end
  end

  // Carry scan flags down the pipe
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_begin_r <= in_bus.begin_token;
      b_eot_r   <= in_bus.end_of_text;
    end
    if (b_valid_r) begin
      c_act_r   <= b_act;
      c_begin_r <= b_begin_r;
      c_eot_r   <= b_eot_r;
    end
  end

  // Follow live transitions early; a stop makes the state irrelevant
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else if (b_valid_r && b_act && trans_rd.live) begin
      cur_r <= trans_rd.next;
    end
  end

  // Update scan activity and saturating length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (c_fire && c_act_r) begin
      active_r <= c_move;
      if (c_move && (cnt_base != LEN_MAX)) begin
        cnt_r <= cnt_base + LENGTH_BITS'(1);
      end else begin
        cnt_r <= cnt_base;
      end
    end
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (c_fire && c_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire && c_emit) begin
      out_kind_r <= c_kept.prio;
      out_len_r  <= TOKEN_LEN_BITS'(cnt_base);
      out_acc_r  <= c_kept.accepts;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.token_kind      = out_kind_r;
  assign out_bus.token_length    = out_len_r;
  assign out_bus.final_accepting = out_acc_r;

endmodule

`default_nettype wire

/* src/dfa_token_scanner.sv */
// Top level of the table-driven DFA token scanner.
//
//   channel   dir   handshake      beat contents
//   in_bus    in    valid/ready    operation, table fields, symbol, begin/end flags
//   out_bus   out   valid/ready    token_kind, token_length, final_accepting
//
// Every item, load or scan, sets a busy flag that holds off the next item: a scan
// reads the transition entry, then the next state's info, each as a registered read.
// A token beat is registered after the stopping scan item passes stages B and C.
// Synchronous active-low reset clears scan control; table contents are undefined
// until loaded, and no clearing pass runs.
// A waiting result beat does not block input; a second result that finds it still
// waiting holds the pipe and drops in_bus.ready until out_bus takes the first.
`default_nettype none

module dfa_token_scanner (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dts_in_if.sink      in_bus,
  dts_out_if.source   out_bus
);
  import dts_pkg::*;

  trans_req_t   trans_req;
  trans_entry_t trans_rd;
  info_req_t    info_req;
  info_entry_t  info_rd_a;
  info_entry_t  info_rd_b;

  dts_scan_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .trans_req (trans_req),
    .trans_rd  (trans_rd),
    .info_req  (info_req),
    .info_rd_a (info_rd_a),
    .info_rd_b (info_rd_b)
  );

  dts_trans_mem u_trans_mem (
    .clk     (clk),
    .req     (trans_req),
    .rd_data (trans_rd)
  );

  dts_info_mem u_info_mem (
    .clk       (clk),
    .req       (info_req),
    .rd_a_data (info_rd_a),
    .rd_b_data (info_rd_b)
  );

endmodule

`default_nettype wire
